[hw/rtl/mpt_pkg.sv]
// Shared types, constants and tables for the marker pose to map position unit.
// Holds the Q30 angle constants, the divide-by-125 remainder table and the Horner divisors.
// No dependencies.
package mpt_pkg;

    localparam int MAX_MARKERS_DEF = 16;

    localparam int MulW  = 33;
    localparam int ProdW = 66;

    localparam int RtabDiv  = 125;
    localparam int RtabSize = 125;

    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic [30:0]        ONE_Q30     = 31'd1073741824;
    localparam logic [13:0]        RECIP_125   = 14'd8389;
    localparam logic signed [13:0] PI_MRAD     = 14'sd3142;
    localparam logic [2:0]         LAST_STEP   = 3'd5;

    typedef logic [RtabSize-1:0][26:0] t_rtab;

    typedef struct packed {
        logic               start;
        logic               cos_sel;
        logic signed [13:0] mrad;
    } t_sin_req;

    typedef struct packed {
        logic done;
        logic found;
    } t_tab_rsp;

    // Entry r holds floor((r * 2^27 + 62) / 125), the fractional part of mrad to Q30.
    function automatic t_rtab f_build_rtab();
        t_rtab tab;
        tab = '0;
        for (int r = 0; r < RtabSize; r++) begin
            tab[r] = 27'((64'(r) * 64'd134217728 + 64'd62) / RtabDiv);
        end
        return tab;
    endfunction

    localparam t_rtab RTAB = f_build_rtab();

    function automatic logic [7:0] f_div(input logic [2:0] step);
        logic [7:0] d;
        case (step)
            3'd0:    d = 8'd156;
            3'd1:    d = 8'd110;
            3'd2:    d = 8'd72;
            3'd3:    d = 8'd42;
            3'd4:    d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

    // Floor of 2^32 divided by the matching divisor.
    function automatic logic [31:0] f_recip(input logic [2:0] step);
        logic [31:0] m;
        case (step)
            3'd0:    m = 32'd27531841;
            3'd1:    m = 32'd39045157;
            3'd2:    m = 32'd59652323;
            3'd3:    m = 32'd102261126;
            3'd4:    m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/mpt_mul.sv]
// Shared signed 33 by 33 multiplier with a registered product.
// Depends on mpt_pkg.
module mpt_mul (
    input  logic                              i_clk,
    input  logic signed [mpt_pkg::MulW-1:0]   i_a,
    input  logic signed [mpt_pkg::MulW-1:0]   i_b,
    output logic signed [mpt_pkg::ProdW-1:0]  o_p
);
    import mpt_pkg::*;

    logic signed [ProdW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= ProdW'(i_a) * ProdW'(i_b);
    end

    assign o_p = r_p;

endmodule

[hw/rtl/mpt_table.sv]
// Marker table memory with append on load and a sequential id search.
// Depends on mpt_pkg.
module mpt_table #(
    parameter int MAX_MARKERS = mpt_pkg::MAX_MARKERS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr,
    input  logic [9:0]              i_wr_id,
    input  logic signed [31:0]      i_wr_x,
    input  logic signed [31:0]      i_wr_y,
    input  logic signed [31:0]      i_wr_z,
    input  logic signed [13:0]      i_wr_rot,
    input  logic                    i_start,
    input  logic [9:0]              i_key,
    output mpt_pkg::t_tab_rsp       o_rsp,
    output logic signed [31:0]      o_x,
    output logic signed [31:0]      o_y,
    output logic signed [31:0]      o_z,
    output logic signed [13:0]      o_rot
);
    import mpt_pkg::*;

    localparam int IdxW = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
    localparam int CntW = $clog2(MAX_MARKERS + 1);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_RD   = 2'd1;
    localparam logic [1:0] T_CMP  = 2'd2;

    logic [9:0]         mem_id  [MAX_MARKERS];
    logic signed [31:0] mem_x   [MAX_MARKERS];
    logic signed [31:0] mem_y   [MAX_MARKERS];
    logic signed [31:0] mem_z   [MAX_MARKERS];
    logic signed [13:0] mem_rot [MAX_MARKERS];

    logic [1:0]         r_state;
    logic [CntW-1:0]    r_count;
    logic [CntW-1:0]    r_idx;
    logic [9:0]         r_key;
    logic [9:0]         r_rd_id;
    logic signed [31:0] r_rd_x;
    logic signed [31:0] r_rd_y;
    logic signed [31:0] r_rd_z;
    logic signed [13:0] r_rd_rot;
    t_tab_rsp           r_rsp;
    logic               wr_ok;

    assign wr_ok = i_wr && (r_count != CntW'(MAX_MARKERS));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem_id[r_count[IdxW-1:0]]  <= i_wr_id;
            mem_x[r_count[IdxW-1:0]]   <= i_wr_x;
            mem_y[r_count[IdxW-1:0]]   <= i_wr_y;
            mem_z[r_count[IdxW-1:0]]   <= i_wr_z;
            mem_rot[r_count[IdxW-1:0]] <= i_wr_rot;
        end
        if (r_state == T_RD) begin
            r_rd_id  <= mem_id[r_idx[IdxW-1:0]];
            r_rd_x   <= mem_x[r_idx[IdxW-1:0]];
            r_rd_y   <= mem_y[r_idx[IdxW-1:0]];
            r_rd_z   <= mem_z[r_idx[IdxW-1:0]];
            r_rd_rot <= mem_rot[r_idx[IdxW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_rsp   <= '0;
        end else begin
            if (wr_ok) begin
                r_count <= r_count + CntW'(1);
            end
            case (r_state)
                T_IDLE: begin
                    r_rsp.done  <= i_start && (r_count == '0);
                    r_rsp.found <= 1'b0;
                    if (i_start) begin
                        r_key <= i_key;
                        r_idx <= '0;
                        if (r_count != '0) begin
                            r_state <= T_RD;
                        end
                    end
                end
                T_RD: begin
                    r_rsp   <= '0;
                    r_state <= T_CMP;
                end
                T_CMP: begin
                    r_rsp.found <= (r_rd_id == r_key);
                    r_rsp.done  <= (r_rd_id == r_key) || ((r_idx + CntW'(1)) == r_count);
                    if (r_rd_id == r_key) begin
                        r_state <= T_IDLE;
                    end else if ((r_idx + CntW'(1)) == r_count) begin
                        r_state <= T_IDLE;
                    end else begin
                        r_idx   <= r_idx + CntW'(1);
                        r_state <= T_RD;
                    end
                end
                default: begin
                    r_rsp   <= '0;
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    assign o_rsp = r_rsp;
    assign o_x   = r_rd_x;
    assign o_y   = r_rd_y;
    assign o_z   = r_rd_z;
    assign o_rot = r_rd_rot;

endmodule

[hw/rtl/mpt_sine.sv]
// Sequenced sine and cosine of a milliradian angle in Q1.15 on the shared multiplier.
// Depends on mpt_pkg; the multiplier lives in the top level.
module mpt_sine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpt_pkg::t_sin_req                 i_req,
    output logic                              o_done,
    output logic signed [15:0]                o_val,
    output logic signed [mpt_pkg::MulW-1:0]   o_mul_a,
    output logic signed [mpt_pkg::MulW-1:0]   o_mul_b,
    input  logic signed [mpt_pkg::ProdW-1:0]  i_mul_p
);
    import mpt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_K    = 4'd1;
    localparam logic [3:0] S_KW   = 4'd2;
    localparam logic [3:0] S_RED  = 4'd3;
    localparam logic [3:0] S_FOLD = 4'd4;
    localparam logic [3:0] S_ABS  = 4'd5;
    localparam logic [3:0] S_X2   = 4'd6;
    localparam logic [3:0] S_X2W  = 4'd7;
    localparam logic [3:0] S_P    = 4'd8;
    localparam logic [3:0] S_Q    = 4'd9;
    localparam logic [3:0] S_QW   = 4'd10;
    localparam logic [3:0] S_V    = 4'd11;
    localparam logic [3:0] S_VW   = 4'd12;

    logic [3:0]         r_state;
    logic               r_cos;
    logic               r_neg;
    logic [13:0]        r_mag;
    logic signed [35:0] r_th;
    logic               r_sneg;
    logic [30:0]        r_x;
    logic [31:0]        r_x2;
    logic [30:0]        r_t;
    logic [31:0]        r_p;
    logic [2:0]         r_i;
    logic               r_done;
    logic signed [15:0] r_val;

    logic [6:0]         k;
    logic [13:0]        rem125;
    logic [33:0]        q_mag;
    logic signed [35:0] th_pos;
    logic signed [35:0] th0;
    logic [31:0]        p30;
    logic [29:0]        q0;
    logic [7:0]         dsel;
    logic [37:0]        q0d;
    logic [32:0]        rem_d;
    logic [30:0]        qq;
    logic [30:0]        t_new;
    logic [30:0]        v;
    logic [16:0]        rnd;
    logic [14:0]        mag15;
    logic signed [15:0] val;

    assign k      = i_mul_p[26:20];
    assign rem125 = r_mag - 14'(k) * 14'd125;
    assign q_mag  = {k, 27'b0} + 34'(RTAB[rem125[6:0]]);
    assign th_pos = $signed({2'b00, q_mag});
    assign th0    = (r_neg ? -th_pos : th_pos) + (r_cos ? HALF_PI_Q30 : 36'sd0);

    assign p30   = i_mul_p[61:30];
    assign q0    = i_mul_p[61:32];
    assign dsel  = f_div(r_i);
    assign q0d   = 38'(q0) * 38'(dsel);
    assign rem_d = {1'b0, r_p} - q0d[32:0];
    assign qq    = 31'(q0) + 31'(rem_d >= 33'(dsel));
    assign t_new = ONE_Q30 - qq;

    assign v     = i_mul_p[60:30];
    assign rnd   = 17'((32'(v) + 32'd16384) >> 15);
    assign mag15 = (rnd > 17'd32767) ? 15'h7fff : rnd[14:0];
    assign val   = r_sneg ? -$signed({1'b0, mag15}) : $signed({1'b0, mag15});

    always_comb begin
        o_mul_a = '0;
        o_mul_b = '0;
        case (r_state)
            S_K: begin
                o_mul_a = $signed(33'(r_mag));
                o_mul_b = $signed(33'(RECIP_125));
            end
            S_X2: begin
                o_mul_a = $signed({2'b00, r_x});
                o_mul_b = $signed({2'b00, r_x});
            end
            S_P: begin
                o_mul_a = $signed({1'b0, r_x2});
                o_mul_b = $signed({2'b00, r_t});
            end
            S_Q: begin
                o_mul_a = $signed({1'b0, p30});
                o_mul_b = $signed({1'b0, f_recip(r_i)});
            end
            S_V: begin
                o_mul_a = $signed({2'b00, r_x});
                o_mul_b = $signed({2'b00, r_t});
            end
            default: begin
                o_mul_a = '0;
                o_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_VW);
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_cos   <= i_req.cos_sel;
                        r_neg   <= i_req.mrad[13];
                        r_mag   <= i_req.mrad[13] ? 14'(-i_req.mrad) : 14'(i_req.mrad);
                        r_state <= S_K;
                    end
                end
                S_K: begin
                    r_state <= S_KW;
                end
                S_KW: begin
                    r_th    <= th0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (r_th > PI_Q30) begin
                        r_th <= r_th - TWO_PI_Q30;
                    end else if (r_th < -PI_Q30) begin
                        r_th <= r_th + TWO_PI_Q30;
                    end else begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    if (r_th > HALF_PI_Q30) begin
                        r_th <= PI_Q30 - r_th;
                    end else if (r_th < -HALF_PI_Q30) begin
                        r_th <= -PI_Q30 - r_th;
                    end
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_sneg  <= r_th[35];
                    r_x     <= r_th[35] ? 31'(-r_th) : 31'(r_th);
                    r_state <= S_X2;
                end
                S_X2: begin
                    r_state <= S_X2W;
                end
                S_X2W: begin
                    r_x2    <= p30;
                    r_t     <= ONE_Q30;
                    r_i     <= '0;
                    r_state <= S_P;
                end
                S_P: begin
                    r_state <= S_Q;
                end
                S_Q: begin
                    r_p     <= p30;
                    r_state <= S_QW;
                end
                S_QW: begin
                    r_t <= t_new;
                    r_i <= r_i + 3'd1;
                    if (r_i == LAST_STEP) begin
                        r_state <= S_V;
                    end else begin
                        r_state <= S_P;
                    end
                end
                S_V: begin
                    r_state <= S_VW;
                end
                S_VW: begin
                    r_val   <= val;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_val  = r_val;

endmodule

[hw/rtl/marker_pose_to_map_position_unit.sv]
// Top level of the marker pose to map position unit: stream ports, sequencer and transforms.
// Depends on mpt_pkg, mpt_mul, mpt_table and mpt_sine.
//
// Channel  | Direction | Transfer carries
// s_axis   | in        | tuser: action; tdata: count, id, translation, rotation, entry pose
// m_axis   | out       | tdata: map_x, map_y, map_z
//
// A load transfer leaves the input open. Most of a detection is four sine evaluations,
// all passing through the one shared multiplier, after a search that visits the table
// one entry at a time.
// Reset clears the entry count, the sequencer and the output valid flag.
// A finished result waits in the output register; the input side stays open meanwhile.
module marker_pose_to_map_position_unit #(
    parameter int MAX_MARKERS = mpt_pkg::MAX_MARKERS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // detected_count, marker_id, trans_x, trans_y, trans_z, rot_z_mrad,
    // entry_pos_x, entry_pos_y, entry_pos_z, entry_rot_mrad, zero fill
    input  logic [239:0] i_s_axis_tdata,
    // action
    input  logic [0:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // map_x, map_y, map_z
    output logic [95:0]  o_m_axis_tdata
);
    import mpt_pkg::*;

    localparam logic [4:0] M_IDLE  = 5'd0;
    localparam logic [4:0] M_SRCH  = 5'd1;
    localparam logic [4:0] M_SGO   = 5'd2;
    localparam logic [4:0] M_SWAIT = 5'd3;
    localparam logic [4:0] M_X0    = 5'd4;
    localparam logic [4:0] M_X1    = 5'd5;
    localparam logic [4:0] M_X2    = 5'd6;
    localparam logic [4:0] M_X3    = 5'd7;
    localparam logic [4:0] M_X4    = 5'd8;
    localparam logic [4:0] M_X5    = 5'd9;
    localparam logic [4:0] M_Y0    = 5'd10;
    localparam logic [4:0] M_Y1    = 5'd11;
    localparam logic [4:0] M_Y2    = 5'd12;
    localparam logic [4:0] M_Y3    = 5'd13;
    localparam logic [4:0] M_Y4    = 5'd14;
    localparam logic [4:0] M_Y5    = 5'd15;
    localparam logic [4:0] M_OUT   = 5'd16;

    localparam logic ACT_LOAD = 1'b0;

    function automatic logic signed [31:0] f_sat32(input logic signed [36:0] v);
        logic signed [31:0] s;
        if (v > 37'sd2147483647) begin
            s = 32'sh7fffffff;
        end else if (v < -37'sd2147483648) begin
            s = 32'sh80000000;
        end else begin
            s = 32'(v);
        end
        return s;
    endfunction

    logic [4:0]         r_state;
    logic [1:0]         r_which;
    logic signed [31:0] r_tx;
    logic signed [31:0] r_ty;
    logic signed [31:0] r_tz;
    logic signed [12:0] r_rz;
    logic signed [15:0] r_s1;
    logic signed [15:0] r_c1;
    logic signed [15:0] r_s2;
    logic signed [15:0] r_c2;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_mx;
    logic signed [31:0] r_my;
    logic signed [31:0] r_mz;
    logic signed [31:0] r_rx;
    logic signed [31:0] r_ry;
    logic signed [31:0] r_rzo;
    logic               r_out_valid;
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;
    logic signed [31:0] r_oz;

    logic               s_acc;
    logic               is_det;
    logic signed [13:0] ang1;
    t_sin_req           sin_req;
    logic               sin_done;
    logic signed [15:0] sin_val;
    logic signed [MulW-1:0]  sin_a;
    logic signed [MulW-1:0]  sin_b;
    logic signed [MulW-1:0]  top_a;
    logic signed [MulW-1:0]  top_b;
    logic signed [MulW-1:0]  mul_a;
    logic signed [MulW-1:0]  mul_b;
    logic signed [ProdW-1:0] mul_p;
    logic signed [49:0] p50;
    logic signed [49:0] acc_r;
    logic signed [34:0] rnd;
    logic signed [35:0] rnd_abs;
    t_tab_rsp           tab_rsp;
    logic signed [31:0] tab_x;
    logic signed [31:0] tab_y;
    logic signed [31:0] tab_z;
    logic signed [13:0] tab_rot;
    logic               out_free;

    assign o_s_axis_tready = (r_state == M_IDLE);
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign is_det = s_acc && (i_s_axis_tuser[0] != ACT_LOAD) && (i_s_axis_tdata[7:0] != 8'd0);

    mpt_table #(
        .MAX_MARKERS(MAX_MARKERS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (s_acc && (i_s_axis_tuser[0] == ACT_LOAD)),
        .i_wr_id  (i_s_axis_tdata[17:8]),
        .i_wr_x   ($signed(i_s_axis_tdata[158:127])),
        .i_wr_y   ($signed(i_s_axis_tdata[190:159])),
        .i_wr_z   ($signed(i_s_axis_tdata[222:191])),
        .i_wr_rot ($signed(i_s_axis_tdata[236:223])),
        .i_start  (is_det),
        .i_key    (i_s_axis_tdata[17:8]),
        .o_rsp    (tab_rsp),
        .o_x      (tab_x),
        .o_y      (tab_y),
        .o_z      (tab_z),
        .o_rot    (tab_rot)
    );

    assign ang1 = (r_rz > 13'sd0) ? (PI_MRAD - 14'(r_rz)) : 14'(r_rz);

    assign sin_req.start   = (r_state == M_SGO);
    assign sin_req.cos_sel = r_which[0];
    assign sin_req.mrad    = r_which[1] ? tab_rot : ang1;

    mpt_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sin_req),
        .o_done  (sin_done),
        .o_val   (sin_val),
        .o_mul_a (sin_a),
        .o_mul_b (sin_b),
        .i_mul_p (mul_p)
    );

    always_comb begin
        top_a = '0;
        top_b = '0;
        case (r_state)
            M_X0: begin
                top_a = MulW'(r_tx);
                top_b = MulW'(r_c1);
            end
            M_X1: begin
                top_a = MulW'(r_tz);
                top_b = MulW'(r_s1);
            end
            M_X2: begin
                top_a = MulW'(r_tz);
                top_b = MulW'(r_c1);
            end
            M_X3: begin
                top_a = MulW'(r_tx);
                top_b = MulW'(r_s1);
            end
            M_Y0: begin
                top_a = MulW'(r_mx);
                top_b = MulW'(r_c2);
            end
            M_Y1: begin
                top_a = MulW'(r_mz);
                top_b = MulW'(r_s2);
            end
            M_Y2: begin
                top_a = MulW'(r_mx);
                top_b = MulW'(r_s2);
            end
            M_Y3: begin
                top_a = MulW'(r_mz);
                top_b = MulW'(r_c2);
            end
            default: begin
                top_a = '0;
                top_b = '0;
            end
        endcase
    end

    assign mul_a = (r_state == M_SWAIT) ? sin_a : top_a;
    assign mul_b = (r_state == M_SWAIT) ? sin_b : top_b;

    mpt_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign p50     = mul_p[49:0];
    assign acc_r   = r_acc + 50'sd16384;
    assign rnd     = acc_r[49:15];
    assign rnd_abs = rnd[34] ? -36'(rnd) : 36'(rnd);
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_which     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == M_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                M_IDLE: begin
                    if (is_det) begin
                        r_tx    <= $signed(i_s_axis_tdata[49:18]);
                        r_ty    <= $signed(i_s_axis_tdata[81:50]);
                        r_tz    <= $signed(i_s_axis_tdata[113:82]);
                        r_rz    <= $signed(i_s_axis_tdata[126:114]);
                        r_state <= M_SRCH;
                    end
                end
                M_SRCH: begin
                    if (tab_rsp.done) begin
                        r_which <= '0;
                        r_state <= tab_rsp.found ? M_SGO : M_IDLE;
                    end
                end
                M_SGO: begin
                    r_state <= M_SWAIT;
                end
                M_SWAIT: begin
                    if (sin_done) begin
                        case (r_which)
                            2'd0:    r_s1 <= sin_val;
                            2'd1:    r_c1 <= sin_val;
                            2'd2:    r_s2 <= sin_val;
                            default: r_c2 <= sin_val;
                        endcase
                        r_which <= r_which + 2'd1;
                        r_state <= (r_which == 2'd3) ? M_X0 : M_SGO;
                    end
                end
                M_X0: begin
                    r_state <= M_X1;
                end
                M_X1: begin
                    r_acc   <= -p50;
                    r_state <= M_X2;
                end
                M_X2: begin
                    r_acc   <= r_acc - p50;
                    r_state <= M_X3;
                end
                M_X3: begin
                    r_mx    <= f_sat32(37'(rnd));
                    r_acc   <= -p50;
                    r_state <= M_X4;
                end
                M_X4: begin
                    r_acc   <= r_acc + p50;
                    r_state <= M_X5;
                end
                M_X5: begin
                    r_mz    <= f_sat32(37'(rnd_abs));
                    r_my    <= f_sat32(37'sd0 - 37'(r_ty));
                    r_state <= M_Y0;
                end
                M_Y0: begin
                    r_state <= M_Y1;
                end
                M_Y1: begin
                    r_acc   <= p50;
                    r_state <= M_Y2;
                end
                M_Y2: begin
                    r_acc   <= r_acc - p50;
                    r_state <= M_Y3;
                end
                M_Y3: begin
                    r_rx    <= f_sat32(37'(rnd) + 37'(tab_x));
                    r_acc   <= p50;
                    r_state <= M_Y4;
                end
                M_Y4: begin
                    r_acc   <= r_acc + p50;
                    r_state <= M_Y5;
                end
                M_Y5: begin
                    r_rzo   <= f_sat32(37'(rnd) + 37'(tab_z));
                    r_ry    <= f_sat32(37'(r_my) + 37'(tab_y));
                    r_state <= M_OUT;
                end
                M_OUT: begin
                    if (out_free) begin
                        r_ox    <= r_rx;
                        r_oy    <= r_ry;
                        r_oz    <= r_rzo;
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_oz, r_oy, r_ox};

endmodule

[hw/rtl/mpt_chk.sv]
// Port-level checker for the marker pose to map position unit, bound to the top level.
// Depends on marker_pose_to_map_position_unit.
module mpt_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [239:0] i_s_axis_tdata,
    input logic [0:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("Output valid dropped before its transfer.");

    a_det_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0]
            && (i_s_axis_tdata[7:0] != 8'd0)) |=> !o_s_axis_tready)
        else $error("Input stayed open after a detection transfer.");

    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser[0]) |=> o_s_axis_tready)
        else $error("A load transfer closed the input.");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("A result appeared without a busy detection.");

endmodule

bind marker_pose_to_map_position_unit mpt_chk u_mpt_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

[dv/tb.sv]
// Self-checking testbench for marker_pose_to_map_position_unit: marker table loads and detections.
// Predicts each map position in fixed point and checks every output transfer against it.
// Depends on the unit's RTL and mpt_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int TableDepth = mpt_pkg::MAX_MARKERS_DEF;
    localparam int RandomItems = 1150;
    localparam longint CycleLimit = 1500000;
    localparam longint OneQ30 = 64'sd1073741824;
    localparam longint PiQ30 = 64'sd3373259426;
    localparam longint TwoPiQ30 = 64'sd6746518852;
    localparam longint HalfPiQ30 = 64'sd1686629713;
    localparam longint PiMrad = 3142;

    typedef enum logic [0:0] {
        ACT_LOAD = 1'b0,
        ACT_DETECT = 1'b1
    } t_action;

    typedef struct {
        t_action             action;
        logic [7:0]          cnt;
        logic [9:0]          id;
        logic signed [31:0]  tx, ty, tz;
        logic signed [12:0]  rz;
        logic signed [31:0]  px, py, pz;
        logic signed [13:0]  rot;
    } t_item;

    typedef struct {
        logic signed [31:0] x, y, z;
    } t_map_pos;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [239:0] s_data = '0;
    logic [0:0]   s_user = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [95:0]  m_data;

    t_item    pending_q[$];
    t_item    cur_item;
    t_map_pos map_expect_q[$];
    logic [9:0]         tab_id[TableDepth];
    logic signed [31:0] tab_px[TableDepth], tab_py[TableDepth], tab_pz[TableDepth];
    logic signed [13:0] tab_rot[TableDepth];
    int  tab_count = 0;
    logic [9:0] known_ids[$];
    int  total_items = 0;
    int  accepted = 0;
    int  n_loads = 0, n_detects = 0, n_results = 0, n_errors = 0;
    int  tx_idle_pct = 0, rx_stall_pct = 0;
    longint cycles = 0;

    marker_pose_to_map_position_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // count, id, tx, ty, tz, rz, px, py, pz, rot
        .i_s_axis_tuser  (s_user),   // action
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)    // map_x, map_y, map_z
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint mrad_q30(longint a);
        longint unsigned m;
        m = (a < 0 ? -a : a) * OneQ30;
        m = (m + 500) / 1000;
        return a < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sine_q15(longint th);
        longint unsigned x, x2, t, v, r;
        longint unsigned divs[6];
        logic neg;
        divs = '{156, 110, 72, 42, 20, 6};
        while (th > PiQ30) th -= TwoPiQ30;
        while (th < -PiQ30) th += TwoPiQ30;
        if (th > HalfPiQ30) th = PiQ30 - th;
        else if (th < -HalfPiQ30) th = -PiQ30 - th;
        neg = th < 0;
        x = neg ? -th : th;
        x2 = (x * x) >> 30;
        t = OneQ30;
        for (int i = 0; i < 6; i++) t = OneQ30 - ((x2 * t) >> 30) / divs[i];
        v = (x * t) >> 30;
        r = (v + (1 << 14)) >> 15;
        if (r > 32767) r = 32767;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint round_q15(longint v);
        return (v + (1 << 14)) >>> 15;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Applies one accepted transfer to the table copy and queues its map position if any.
    task automatic compute_map_position(input t_item it);
        int hit;
        longint ang, s1, c1, s2, c2, mx, my, mz, x, y, z;
        t_map_pos p;
        hit = -1;
        if (it.action == ACT_LOAD) begin
            n_loads++;
            if (tab_count < TableDepth) begin
                tab_id[tab_count] = it.id;
                tab_px[tab_count] = it.px;
                tab_py[tab_count] = it.py;
                tab_pz[tab_count] = it.pz;
                tab_rot[tab_count] = it.rot;
                tab_count++;
            end
            return;
        end
        n_detects++;
        if (it.cnt == 0) return;
        for (int i = 0; i < tab_count; i++) begin
            if (hit < 0 && tab_id[i] == it.id) hit = i;
        end
        if (hit < 0) return;
        ang = it.rz > 0 ? PiMrad - longint'(it.rz) : longint'(it.rz);
        s1 = sine_q15(mrad_q30(ang));
        c1 = sine_q15(mrad_q30(ang) + HalfPiQ30);
        mx = sat32(round_q15(-longint'(it.tx) * c1 - longint'(it.tz) * s1));
        my = sat32(-longint'(it.ty));
        mz = round_q15(-longint'(it.tz) * c1 + longint'(it.tx) * s1);
        mz = sat32(mz < 0 ? -mz : mz);
        s2 = sine_q15(mrad_q30(tab_rot[hit]));
        c2 = sine_q15(mrad_q30(tab_rot[hit]) + HalfPiQ30);
        x = round_q15(mx * c2 - mz * s2) + tab_px[hit];
        y = my + tab_py[hit];
        z = round_q15(mx * s2 + mz * c2) + tab_pz[hit];
        p.x = sat32(x);
        p.y = sat32(y);
        p.z = sat32(z);
        map_expect_q = {map_expect_q, p};
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'sd2147483647 - $urandom_range(3);
            2: return -32'sd2147483648 + $urandom_range(3);
            default: return $signed($urandom_range(20 << 16)) - (10 << 16);
        endcase
    endfunction

    task automatic add_item(input t_action a, input logic [7:0] cnt, input logic [9:0] id,
                            input logic signed [31:0] tx, ty, tz, input logic signed [12:0] rz,
                            input logic signed [31:0] px, py, pz,
                            input logic signed [13:0] rot);
        t_item it;
        it = '{a, cnt, id, tx, ty, tz, rz, px, py, pz, rot};
        if (a == ACT_LOAD && known_ids.size() < TableDepth) known_ids = {known_ids, id};
        pending_q = {pending_q, it};
    endtask

    task automatic add_random_load();
        add_item(ACT_LOAD, 8'($urandom), 10'($urandom), $urandom, $urandom, $urandom,
                 13'($urandom), rand_coord(), rand_coord(), rand_coord(), 14'($urandom));
    endtask

    task automatic add_random_detect();
        logic [9:0] id;
        logic [7:0] cnt;
        id = $urandom_range(99) < 92 ? known_ids[$urandom_range(known_ids.size() - 1)]
                                     : 10'($urandom);
        cnt = $urandom_range(99) < 8 ? 8'd0 : 8'($urandom_range(255, 1));
        add_item(ACT_DETECT, cnt, id, rand_coord(), rand_coord(), rand_coord(),
                 $urandom_range(99) < 80 ? 13'($signed($urandom_range(6284)) - 3142)
                                         : 13'($urandom),
                 $urandom, $urandom, $urandom, 14'($urandom));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                compute_map_position(cur_item);
                accepted++;
            end
            case (accepted * 4 / total_items)
                0: tx_idle_pct = 0;
                1: tx_idle_pct = 50;
                2: tx_idle_pct = 0;
                default: tx_idle_pct = 23;
            endcase
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_item = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_user <= cur_item.action;
                    s_data <= {3'b0, cur_item.rot, cur_item.pz, cur_item.py, cur_item.px,
                               cur_item.rz, cur_item.tz, cur_item.ty, cur_item.tx,
                               cur_item.id, cur_item.cnt};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_map_pos p;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (map_expect_q.size() == 0) begin
                    $error("Unexpected output transfer: %h", m_data);
                    n_errors++;
                end else begin
                    p = map_expect_q.pop_front();
                    if (m_data[31:0] !== p.x) begin
                        $error("map_x expected %0d actual %0d", p.x, $signed(m_data[31:0]));
                        n_errors++;
                    end
                    if (m_data[63:32] !== p.y) begin
                        $error("map_y expected %0d actual %0d", p.y, $signed(m_data[63:32]));
                        n_errors++;
                    end
                    if (m_data[95:64] !== p.z) begin
                        $error("map_z expected %0d actual %0d", p.z, $signed(m_data[95:64]));
                        n_errors++;
                    end
                end
            end
            rx_stall_pct = (accepted * 4 / total_items == 2) ? 50 :
                           (accepted * 4 / total_items == 3) ? 23 : 0;
            m_ready <= $urandom_range(99) >= rx_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        // Detections against an empty table find nothing.
        add_item(ACT_DETECT, 8'd1, 10'd0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(ACT_LOAD, 8'hFF, 10'd0, -1, -1, -1, -1,
                 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 14'sd6284);
        add_item(ACT_LOAD, 8'h00, 10'h3FF, 0, 0, 0, 0,
                 32'sh80000000, 32'sh80000000, 32'sh80000000, -14'sd6284);
        add_item(ACT_LOAD, 8'd3, 10'd0, 0, 0, 0, 0, 32'sd65536, -32'sd65536, 0, 14'sd0);
        add_item(ACT_LOAD, 8'd3, 10'd5, 0, 0, 0, 0, 32'sd123456, 32'sd7, -32'sd9, 14'sd8191);
        add_item(ACT_LOAD, 8'd3, 10'd6, 0, 0, 0, 0, -32'sd5, 32'sd3, 32'sd1, -14'sd8192);
        add_item(ACT_DETECT, 8'd1, 10'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                 13'sd0, 0, 0, 0, 0);
        add_item(ACT_DETECT, 8'hFF, 10'h3FF, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 13'sd3142, 0, 0, 0, 0);
        add_item(ACT_DETECT, 8'd2, 10'd5, 32'sd65536, 32'sd65536, -32'sd65536,
                 -13'sd3142, 0, 0, 0, 0);
        add_item(ACT_DETECT, 8'd2, 10'd6, 32'sd100000, -32'sd1, 32'sd200000,
                 13'sd4095, 0, 0, 0, 0);
        add_item(ACT_DETECT, 8'd2, 10'd5, -32'sd100000, 32'sd1, 32'sd200000,
                 -13'sd4096, 0, 0, 0, 0);
        add_item(ACT_DETECT, 8'd1, 10'd1, 32'sd5, 32'sd5, 32'sd5, 13'sd1, 0, 0, 0, 0);
        add_item(ACT_DETECT, 8'd0, 10'd0, 32'sd5, 32'sd5, 32'sd5, 13'sd1, 0, 0, 0, 0);
        add_item(ACT_DETECT, 8'd1, 10'd6, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                 -13'sd1, 0, 0, 0, 0);
        while (known_ids.size() < TableDepth) add_random_load();
        // The table is full now, so this load changes nothing.
        add_item(ACT_LOAD, 8'd1, 10'd777, 0, 0, 0, 0, 32'sd1, 32'sd1, 32'sd1, 14'sd1);
        add_item(ACT_DETECT, 8'd1, 10'd777, 32'sd5, 32'sd5, 32'sd5, 13'sd1, 0, 0, 0, 0);
        for (int i = 0; i < RandomItems; i++) begin
            if ($urandom_range(99) < 6) add_random_load();
            else add_random_detect();
        end
        total_items = pending_q.size();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_q.size() == 0 && !s_valid);
        wait (map_expect_q.size() == 0);
        repeat (400) @(posedge i_clk);
        $display("Covered %0d loads and %0d detections, %0d map positions checked.",
                 n_loads, n_detects, n_results);
        if (n_errors == 0 && map_expect_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
